// ----- rtl/core/gdc_pkg.sv -----
package gdc_pkg;

    localparam int unsigned DAY_W = 23;
    localparam int unsigned STEP_W = 5;

    localparam logic [STEP_W-1:0] YEAR_STEPS  = 5'd15;
    localparam logic [STEP_W-1:0] MONTH_STEPS = 5'd11;
    localparam logic [STEP_W-1:0] WDAY_STEPS  = 5'd20;

    localparam logic [3:0]       MONTHS_PER_YEAR = 4'd12;
    localparam logic [DAY_W-1:0] WEEK_DAYS       = 23'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_YEAR,
        ST_MONTH,
        ST_WDAY,
        ST_FINISH
    } state_t;

    typedef struct packed {
        state_t              phase;
        logic [STEP_W-1:0]   step;
        logic                last;
    } ctrl_t;

    // Year-decomposition schedule: 400-year blocks (6 bits), centuries (2),
    // 4-year blocks (5), single years (2). Years and days move in lockstep.
    function automatic logic [DAY_W-1:0] step_years(input logic [3:0] idx);
        logic [DAY_W-1:0] v;
        unique case (idx)
            4'd0:    v = 23'd12800;
            4'd1:    v = 23'd6400;
            4'd2:    v = 23'd3200;
            4'd3:    v = 23'd1600;
            4'd4:    v = 23'd800;
            4'd5:    v = 23'd400;
            4'd6:    v = 23'd200;
            4'd7:    v = 23'd100;
            4'd8:    v = 23'd64;
            4'd9:    v = 23'd32;
            4'd10:   v = 23'd16;
            4'd11:   v = 23'd8;
            4'd12:   v = 23'd4;
            4'd13:   v = 23'd2;
            4'd14:   v = 23'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [DAY_W-1:0] step_days(input logic [3:0] idx);
        logic [DAY_W-1:0] v;
        unique case (idx)
            4'd0:    v = 23'd4675104;
            4'd1:    v = 23'd2337552;
            4'd2:    v = 23'd1168776;
            4'd3:    v = 23'd584388;
            4'd4:    v = 23'd292194;
            4'd5:    v = 23'd146097;
            4'd6:    v = 23'd73048;
            4'd7:    v = 23'd36524;
            4'd8:    v = 23'd23376;
            4'd9:    v = 23'd11688;
            4'd10:   v = 23'd5844;
            4'd11:   v = 23'd2922;
            4'd12:   v = 23'd1461;
            4'd13:   v = 23'd730;
            4'd14:   v = 23'd365;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [4:0] month_days(input logic leap, input logic [3:0] m);
        logic [4:0] v;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: v = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     v = 5'd30;
            4'd2:    v = leap ? 5'd29 : 5'd28;
            default: v = 5'd0;
        endcase
        return v;
    endfunction

    // days before the first of month m in a common year
    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] v;
        unique case (m)
            4'd1:    v = 9'd0;
            4'd2:    v = 9'd31;
            4'd3:    v = 9'd59;
            4'd4:    v = 9'd90;
            4'd5:    v = 9'd120;
            4'd6:    v = 9'd151;
            4'd7:    v = 9'd181;
            4'd8:    v = 9'd212;
            4'd9:    v = 9'd243;
            4'd10:   v = 9'd273;
            4'd11:   v = 9'd304;
            4'd12:   v = 9'd334;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/gregorian_date_day_number_converter_core.sv -----
// Gregorian date <-> day number converter.
// Input channel s_*: one request per transaction. s_command 0 converts the
// date in s_day_of_month/s_month_number/s_year_number to a day count since
// 1 Jan of year 1; s_command 1 converts s_elapsed_days_in back to a date.
// Result channel m_*: one result per request. m_valid_res is 0 with all
// other fields 0 when the date or count is out of range.
// Both channels use valid/ready; a transaction completes when both are high.
// The next request is taken once the result register is loaded and the
// sequencer is back in idle; the block works on one request at a time.
// The work is done by the single compare-subtract/add step unit: 15 steps
// of year decomposition, 1 day fix-up or 11 month-search steps, 20 steps of
// modulo-7 reduction, and then the result register is loaded.
// s_ready is high only while the sequencer is idle. The result register lets
// a new request be accepted while an old result waits; if that one is still
// not taken when the next result is ready, the sequencer holds until m_ready.
// aresetn (synchronous, active low) returns the sequencer to idle and drops
// m_valid; no clearing pass is needed.
module gregorian_date_day_number_converter_core
    import gdc_pkg::*;
#(
    parameter int MAX_YEAR = 9999
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic [4:0]  s_day_of_month,
    input  logic [3:0]  s_month_number,
    input  logic [13:0] s_year_number,
    input  logic [21:0] s_elapsed_days_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_valid_res,
    output logic [21:0] m_elapsed_days,
    output logic [16:0] m_elapsed_months,
    output logic [2:0]  m_weekday_index,
    output logic [4:0]  m_result_day,
    output logic [3:0]  m_result_month,
    output logic [13:0] m_result_year
);

    localparam int unsigned LIMIT_DAYS =
        365 * MAX_YEAR + MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400;
    localparam logic [DAY_W-1:0] LIMIT_W    = LIMIT_DAYS[DAY_W-1:0];
    localparam logic [13:0]      MAX_YEAR_W = MAX_YEAR[13:0];

    ctrl_t ctrl;
    logic  start;
    logic  out_free;

    logic              cmd_reg;
    logic [4:0]        day_reg;
    logic [3:0]        mon_reg;
    logic [13:0]       yr_reg;
    logic [21:0]       cnt_reg;
    logic [DAY_W-1:0]  rem_reg;
    logic [DAY_W-1:0]  acc_reg;
    logic [1:0]        b_reg;
    logic [4:0]        c_reg;
    logic [1:0]        e_reg;
    logic [3:0]        month_reg;
    logic [4:0]        found_day_reg;

    logic [DAY_W-1:0]  sub_val, add_val, rem_out, acc_out;
    logic              take;
    logic              leap;
    logic [DAY_W-1:0]  fix_days;

    logic              m_valid_reg;
    logic              valid_res_reg;
    logic [21:0]       elapsed_days_reg;
    logic [16:0]       elapsed_months_reg;
    logic [2:0]        weekday_reg;
    logic [4:0]        result_day_reg;
    logic [3:0]        result_month_reg;
    logic [13:0]       result_year_reg;
    logic              res_ok;
    logic [13:0]       sel_year;
    logic [3:0]        sel_mon;
    logic [17:0]       year_m1;
    logic [17:0]       months_full;

    assign s_ready  = (ctrl.phase == ST_IDLE);
    assign start    = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    gdc_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .cmd      (cmd_reg),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

    gdc_step_unit u_step (
        .rem_in  (rem_reg),
        .acc_in  (acc_reg),
        .sub_val (sub_val),
        .add_val (add_val),
        .take    (take),
        .rem_out (rem_out),
        .acc_out (acc_out)
    );

    // (year-1) = 400a + 100b + 4c + e; year is leap when e is 3 and either
    // c is not 24 (the year within the century is not 99) or the 400-year remainder is 399
    assign leap = (e_reg == 2'd3) && ((c_reg != 5'd24) || (b_reg == 2'd3));

    assign fix_days = 23'(month_start(mon_reg))
                    + 23'(leap && (mon_reg > 4'd2))
                    + 23'(day_reg) - 23'd1;

    always_comb begin
        sub_val = '0;
        add_val = '0;
        unique case (ctrl.phase)
            ST_YEAR: begin
                // date: consume years, add days; count: the reverse
                sub_val = cmd_reg ? step_days(ctrl.step[3:0]) : step_years(ctrl.step[3:0]);
                add_val = cmd_reg ? step_years(ctrl.step[3:0]) : step_days(ctrl.step[3:0]);
            end
            ST_MONTH: begin
                if (!cmd_reg) begin
                    add_val = fix_days;
                end else if (month_reg < MONTHS_PER_YEAR) begin
                    sub_val = 23'(month_days(leap, month_reg));
                end else begin
                    sub_val = '1;
                end
            end
            ST_WDAY: begin
                sub_val = WEEK_DAYS << (WDAY_STEPS - 5'd1 - ctrl.step);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            cmd_reg   <= s_command;
            day_reg   <= s_day_of_month;
            mon_reg   <= s_month_number;
            yr_reg    <= s_year_number;
            cnt_reg   <= s_elapsed_days_in;
            rem_reg   <= s_command ? 23'(s_elapsed_days_in) : 23'(s_year_number - 14'd1);
            acc_reg   <= s_command ? 23'd1 : 23'd0;
            month_reg <= 4'd1;
        end else begin
            case (ctrl.phase)
                ST_YEAR: begin
                    rem_reg <= rem_out;
                    acc_reg <= acc_out;
                    if (ctrl.step == 5'd6 || ctrl.step == 5'd7)
                        b_reg <= {b_reg[0], take};
                    if (ctrl.step >= 5'd8 && ctrl.step <= 5'd12)
                        c_reg <= {c_reg[3:0], take};
                    if (ctrl.step == 5'd13 || ctrl.step == 5'd14)
                        e_reg <= {e_reg[0], take};
                end
                ST_MONTH: begin
                    acc_reg <= acc_out;
                    if (cmd_reg && take)
                        month_reg <= month_reg + 4'd1;
                    if (ctrl.last) begin
                        found_day_reg <= rem_out[4:0] + 5'd1;
                        rem_reg       <= cmd_reg ? 23'(cnt_reg) : acc_out;
                    end else begin
                        rem_reg <= rem_out;
                    end
                end
                ST_WDAY: begin
                    rem_reg <= rem_out;
                end
                default: ;
            endcase
        end
    end

    assign sel_year    = cmd_reg ? acc_reg[13:0] : yr_reg;
    assign sel_mon     = cmd_reg ? month_reg : mon_reg;
    assign year_m1     = 18'(sel_year) - 18'd1;
    assign months_full = (year_m1 << 3) + (year_m1 << 2) + 18'(sel_mon) - 18'd1;

    always_comb begin
        if (cmd_reg) begin
            res_ok = ({1'b0, cnt_reg} < LIMIT_W);
        end else begin
            res_ok = (yr_reg != 14'd0) && (yr_reg <= MAX_YEAR_W)
                  && (mon_reg >= 4'd1) && (mon_reg <= MONTHS_PER_YEAR)
                  && (day_reg != 5'd0) && (day_reg <= month_days(leap, mon_reg));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.phase == ST_FINISH && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.phase == ST_FINISH && out_free) begin
            valid_res_reg      <= res_ok;
            elapsed_days_reg   <= res_ok ? (cmd_reg ? cnt_reg : acc_reg[21:0]) : 22'd0;
            elapsed_months_reg <= res_ok ? months_full[16:0] : 17'd0;
            weekday_reg        <= res_ok ? rem_reg[2:0] : 3'd0;
            result_day_reg     <= res_ok ? (cmd_reg ? found_day_reg : day_reg) : 5'd0;
            result_month_reg   <= res_ok ? sel_mon : 4'd0;
            result_year_reg    <= res_ok ? sel_year : 14'd0;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_valid_res      = valid_res_reg;
    assign m_elapsed_days   = elapsed_days_reg;
    assign m_elapsed_months = elapsed_months_reg;
    assign m_weekday_index  = weekday_reg;
    assign m_result_day     = result_day_reg;
    assign m_result_month   = result_month_reg;
    assign m_result_year    = result_year_reg;

endmodule

// ----- rtl/core/gdc_step_unit.sv -----
module gdc_step_unit
    import gdc_pkg::*;
(
    input  logic [DAY_W-1:0] rem_in,
    input  logic [DAY_W-1:0] acc_in,
    input  logic [DAY_W-1:0] sub_val,
    input  logic [DAY_W-1:0] add_val,
    output logic             take,
    output logic [DAY_W-1:0] rem_out,
    output logic [DAY_W-1:0] acc_out
);

    // conditional subtract on the remainder, matching add on the accumulator
    assign take    = (rem_in >= sub_val);
    assign rem_out = take ? (rem_in - sub_val) : rem_in;
    assign acc_out = take ? (acc_in + add_val) : acc_in;

endmodule

// ----- rtl/core/gdc_seq.sv -----
module gdc_seq
    import gdc_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  start,
    input  logic  cmd,
    input  logic  out_free,
    output ctrl_t ctrl
);

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg + 5'd1;
        last       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                step_next = '0;
                if (start) state_next = ST_YEAR;
            end
            ST_YEAR: begin
                last = (step_reg == YEAR_STEPS - 5'd1);
                if (last) begin
                    state_next = ST_MONTH;
                    step_next  = '0;
                end
            end
            ST_MONTH: begin
                // date-to-count needs a single fix-up step
                last = cmd ? (step_reg == MONTH_STEPS - 5'd1) : 1'b1;
                if (last) begin
                    state_next = ST_WDAY;
                    step_next  = '0;
                end
            end
            ST_WDAY: begin
                last = (step_reg == WDAY_STEPS - 5'd1);
                if (last) begin
                    state_next = ST_FINISH;
                    step_next  = '0;
                end
            end
            ST_FINISH: begin
                step_next = '0;
                if (out_free) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
                step_next  = '0;
            end
        endcase
    end

    assign ctrl.phase = state_reg;
    assign ctrl.step  = step_reg;
    assign ctrl.last  = last;

endmodule

// ----- rtl/core/gdc_checker.sv -----
module gdc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_valid_res,
    input logic [21:0] m_elapsed_days,
    input logic [16:0] m_elapsed_months,
    input logic [2:0]  m_weekday_index,
    input logic [4:0]  m_result_day,
    input logic [3:0]  m_result_month,
    input logic [13:0] m_result_year
);

    // one request at a time: busy right after a transaction
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("s_ready high right after an input transaction");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_valid_res) |->
            (m_elapsed_days == 22'd0) && (m_elapsed_months == 17'd0)
            && (m_weekday_index == 3'd0) && (m_result_day == 5'd0)
            && (m_result_month == 4'd0) && (m_result_year == 14'd0))
        else $error("invalid result carries nonzero fields");

    a_valid_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_valid_res) |->
            (m_weekday_index <= 3'd6) && (m_result_day != 5'd0)
            && (m_result_month != 4'd0) && (m_result_month <= 4'd12)
            && (m_result_year != 14'd0))
        else $error("valid result with out-of-range date fields");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_valid_res)
            && $stable(m_elapsed_days) && $stable(m_elapsed_months)
            && $stable(m_weekday_index) && $stable(m_result_day)
            && $stable(m_result_month) && $stable(m_result_year))
        else $error("result changed while stalled");

endmodule

bind gregorian_date_day_number_converter_core gdc_checker u_gdc_checker (.*);

// ----- dv/gregorian_date_day_number_converter_core_tb.sv -----
module gregorian_date_day_number_converter_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_YEAR     = 9999;
    localparam int LAST_COUNT   = 3652058;  // 31 Dec of MAX_YEAR
    localparam int RANDOM_ITEMS = 850;
    localparam int HOLD_CYCLES  = 500;
    localparam int DRAIN_CYCLES = 60;

    localparam logic CMD_TO_DAYS = 1'b0;
    localparam logic CMD_TO_DATE = 1'b1;

    typedef struct {
        logic        cmd;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [21:0] count;
    } date_request_t;

    typedef struct {
        logic        ok;
        logic [21:0] days;
        logic [16:0] months;
        logic [2:0]  wday;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
    } date_result_t;

    typedef struct {
        date_request_t rq;
        bit            typed;
        date_result_t  want;
    } directed_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_command;
    logic [4:0]  s_day_of_month;
    logic [3:0]  s_month_number;
    logic [13:0] s_year_number;
    logic [21:0] s_elapsed_days_in;
    logic        m_valid;
    logic        m_ready;
    logic        m_valid_res;
    logic [21:0] m_elapsed_days;
    logic [16:0] m_elapsed_months;
    logic [2:0]  m_weekday_index;
    logic [4:0]  m_result_day;
    logic [3:0]  m_result_month;
    logic [13:0] m_result_year;

    date_result_t  expected_results[$];
    directed_row_t directed[$];

    int  fail_count;
    int  results_checked;
    int  date_requests;
    int  count_requests;
    int  invalid_requests;
    int  sender_quiet;
    bit  hold_done;

    int special_years[12] = '{1, 2, 4, 100, 400, 1600, 1900, 2000, 2100, 9996, 9998, 9999};

    gregorian_date_day_number_converter_core #(
        .MAX_YEAR(MAX_YEAR)
    ) u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_day_of_month    (s_day_of_month),
        .s_month_number    (s_month_number),
        .s_year_number     (s_year_number),
        .s_elapsed_days_in (s_elapsed_days_in),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_valid_res       (m_valid_res),
        .m_elapsed_days    (m_elapsed_days),
        .m_elapsed_months  (m_elapsed_months),
        .m_weekday_index   (m_weekday_index),
        .m_result_day      (m_result_day),
        .m_result_month    (m_result_month),
        .m_result_year     (m_result_year)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic longint days_in_month(longint y, longint m);
        bit leap;
        leap = ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    function automatic longint days_before(longint y);
        longint p;
        p = y - 1;
        return 365 * p + p / 4 - p / 100 + p / 400;
    endfunction

    function automatic date_result_t convert_date(date_request_t rq);
        date_result_t res;
        longint days, rem, q400, q100, q4, q1, y, m, d;
        res = '{default: '0};
        if (rq.cmd == CMD_TO_DAYS) begin
            y = longint'(rq.year);
            m = longint'(rq.month);
            d = longint'(rq.day);
            if (y < 1 || y > MAX_YEAR || m < 1 || m > 12) return res;
            if (d < 1 || d > days_in_month(y, m)) return res;
            days = days_before(y) + d - 1;
            for (longint k = 1; k < m; k++) days += days_in_month(y, k);
        end else begin
            days = longint'(rq.count);
            if (days >= days_before(longint'(MAX_YEAR + 1))) return res;
            q400 = days / 146097;
            rem  = days % 146097;
            q100 = rem / 36524;
            if (q100 > 3) q100 = 3;
            rem  = rem - q100 * 36524;
            q4   = rem / 1461;
            rem  = rem % 1461;
            q1   = rem / 365;
            if (q1 > 3) q1 = 3;
            rem  = rem - q1 * 365;
            y    = q400 * 400 + q100 * 100 + q4 * 4 + q1 + 1;
            m    = 1;
            while (m < 12 && rem >= days_in_month(y, m)) begin
                rem = rem - days_in_month(y, m);
                m++;
            end
            d = rem + 1;
        end
        res.ok     = 1'b1;
        res.days   = days[21:0];
        res.months = 17'((y - 1) * 12 + (m - 1));
        res.wday   = 3'(days % 7);
        res.day    = d[4:0];
        res.month  = m[3:0];
        res.year   = y[13:0];
        return res;
    endfunction

    task automatic add_row(logic cmd, int d, int mo, int y, int cnt, bit typed,
                           date_result_t want);
        directed_row_t row;
        row.rq    = '{cmd, d[4:0], mo[3:0], y[13:0], cnt[21:0]};
        row.typed = typed;
        row.want  = want;
        directed.push_back(row);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 20);
        return $urandom_range(21, 120);
    endfunction

    // drive one request and wait for the transaction; expectation queued on acceptance
    task automatic send_request(date_request_t rq, date_result_t want);
        @(negedge aclk);
        s_valid           = 1'b1;
        s_command         = rq.cmd;
        s_day_of_month    = rq.day;
        s_month_number    = rq.month;
        s_year_number     = rq.year;
        s_elapsed_days_in = rq.count;
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(want);
        if (rq.cmd == CMD_TO_DAYS) date_requests++;
        else count_requests++;
        if (!want.ok) invalid_requests++;
    endtask

    task automatic pause_sender();
        int gap;
        if (sender_quiet > 0) begin
            sender_quiet--;
            gap = 0;
        end else begin
            if ($urandom_range(0, 99) < 3) sender_quiet = $urandom_range(20, 60);
            gap = pick_gap();
        end
        if (gap > 0) begin
            @(negedge aclk);
            s_valid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic note_failure(string what, date_result_t want, date_result_t got);
        fail_count++;
        if (fail_count <= 10) begin
            $display("[%0t] %s", $realtime, what);
            $display("    expected ok=%0d days=%0d months=%0d wday=%0d date=%0d/%0d/%0d",
                     want.ok, want.days, want.months, want.wday,
                     want.day, want.month, want.year);
            $display("    actual   ok=%0d days=%0d months=%0d wday=%0d date=%0d/%0d/%0d",
                     got.ok, got.days, got.months, got.wday,
                     got.day, got.month, got.year);
        end
    endtask

    // result monitor
    always @(posedge aclk) begin
        date_result_t want;
        date_result_t got;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_valid_res, m_elapsed_days, m_elapsed_months, m_weekday_index,
                    m_result_day, m_result_month, m_result_year};
            results_checked++;
            if (expected_results.size() == 0) begin
                note_failure("result transaction with nothing expected", '{default: '0}, got);
            end else begin
                want = expected_results.pop_front();
                if (got.ok !== want.ok || got.days !== want.days ||
                    got.months !== want.months || got.wday !== want.wday ||
                    got.day !== want.day || got.month !== want.month ||
                    got.year !== want.year)
                    note_failure("result mismatch", want, got);
            end
        end
    end

    // result side: random stalls, quiet stretches, and one long hold-off
    initial begin
        int stall;
        int quiet_left;
        quiet_left = 0;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (!hold_done && results_checked >= 150) begin
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_done = 1'b1;
                m_ready = 1'b1;
            end else begin
                if (quiet_left > 0) begin
                    quiet_left--;
                    stall = 0;
                end else begin
                    if ($urandom_range(0, 99) < 3) quiet_left = $urandom_range(20, 80);
                    stall = pick_gap();
                end
                if (stall == 0) begin
                    m_ready = 1'b1;
                end else begin
                    m_ready = 1'b0;
                    repeat (stall - 1) @(negedge aclk);
                end
            end
        end
    end

    initial begin
        date_request_t rq;
        date_result_t  bad;
        int            sel;
        int            y;
        int            mo;
        int            dim;

        fail_count        = 0;
        results_checked   = 0;
        date_requests     = 0;
        count_requests    = 0;
        invalid_requests  = 0;
        sender_quiet      = 0;
        hold_done         = 1'b0;
        aresetn           = 1'b0;
        s_valid           = 1'b0;
        s_command         = CMD_TO_DAYS;
        s_day_of_month    = '0;
        s_month_number    = '0;
        s_year_number     = '0;
        s_elapsed_days_in = '0;
        bad               = '{default: '0};

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // first day, last day, range errors, leap rules, then the reverse direction
        add_row(CMD_TO_DAYS, 1, 1, 1, 0, 1, '{1'b1, 22'd0, 17'd0, 3'd0, 5'd1, 4'd1, 14'd1});
        add_row(CMD_TO_DAYS, 31, 12, 9999, 4194303, 1,
                '{1'b1, 22'd3652058, 17'd119987, 3'd4, 5'd31, 4'd12, 14'd9999});
        add_row(CMD_TO_DAYS, 1, 1, 0, 0, 1, bad);
        add_row(CMD_TO_DAYS, 1, 1, 10000, 0, 1, bad);
        add_row(CMD_TO_DAYS, 31, 15, 16383, 4194303, 1, bad);
        add_row(CMD_TO_DAYS, 15, 0, 2000, 0, 1, bad);
        add_row(CMD_TO_DAYS, 15, 13, 2000, 0, 1, bad);
        add_row(CMD_TO_DAYS, 0, 1, 2000, 0, 1, bad);
        add_row(CMD_TO_DAYS, 31, 4, 2000, 0, 1, bad);
        add_row(CMD_TO_DAYS, 29, 2, 2000, 0, 0, bad);
        add_row(CMD_TO_DAYS, 29, 2, 1900, 0, 1, bad);
        add_row(CMD_TO_DAYS, 29, 2, 2024, 0, 0, bad);
        add_row(CMD_TO_DAYS, 29, 2, 2023, 0, 1, bad);
        add_row(CMD_TO_DAYS, 30, 2, 2024, 0, 1, bad);
        add_row(CMD_TO_DAYS, 31, 12, 400, 0, 0, bad);
        add_row(CMD_TO_DATE, 0, 0, 0, 0, 1, '{1'b1, 22'd0, 17'd0, 3'd0, 5'd1, 4'd1, 14'd1});
        add_row(CMD_TO_DATE, 31, 15, 16383, 3652058, 1,
                '{1'b1, 22'd3652058, 17'd119987, 3'd4, 5'd31, 4'd12, 14'd9999});
        add_row(CMD_TO_DATE, 0, 0, 0, 3652059, 1, bad);
        add_row(CMD_TO_DATE, 31, 15, 16383, 4194303, 1, bad);
        add_row(CMD_TO_DATE, 0, 0, 0, 146096, 0, bad);
        add_row(CMD_TO_DATE, 0, 0, 0, 146097, 0, bad);
        add_row(CMD_TO_DATE, 0, 0, 0, 1460, 0, bad);
        add_row(CMD_TO_DATE, 0, 0, 0, 36524, 0, bad);
        add_row(CMD_TO_DATE, 0, 0, 0, 730119, 0, bad);

        foreach (directed[i]) begin
            send_request(directed[i].rq,
                         directed[i].typed ? directed[i].want : convert_date(directed[i].rq));
            pause_sender();
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            sel      = $urandom_range(0, 99);
            rq.cmd   = 1'($urandom_range(0, 1));
            rq.day   = 5'($urandom);
            rq.month = 4'($urandom);
            rq.year  = 14'($urandom);
            rq.count = 22'($urandom);
            if (rq.cmd == CMD_TO_DAYS) begin
                if (sel < 93) begin
                    y  = (sel < 70) ? $urandom_range(1, MAX_YEAR)
                                    : special_years[$urandom_range(0, 11)];
                    mo = (sel >= 70 && sel < 80) ? 2 : $urandom_range(1, 12);
                    dim = int'(days_in_month(longint'(y), longint'(mo)));
                    rq.year  = y[13:0];
                    rq.month = mo[3:0];
                    if (sel < 85) rq.day = 5'($urandom_range(1, dim));
                    else rq.day = 5'(($urandom_range(0, 1) == 1) ? dim + 1 : 0);
                end
                // else: random fields, mostly out of range
            end else begin
                if (sel < 75) begin
                    rq.count = 22'($urandom_range(0, LAST_COUNT));
                end else if (sel < 88) begin
                    // around a new year
                    y = $urandom_range(1, MAX_YEAR);
                    rq.count = 22'(days_before(longint'(y))
                                   - ((y > 1) ? $urandom_range(0, 1) : 0));
                end else if (sel < 94) begin
                    rq.count = 22'($urandom_range(LAST_COUNT + 1, 4194303));
                end
            end
            send_request(rq, convert_date(rq));
            pause_sender();
        end

        @(negedge aclk);
        s_valid = 1'b0;

        for (int i = 0; i < 200000 && expected_results.size() != 0; i++) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_results.size() != 0) begin
            fail_count++;
            $display("%0d expected results never arrived", expected_results.size());
        end

        $display("Ran %0d date-to-count and %0d count-to-date requests, %0d of them out of range,",
                 date_requests, count_requests, invalid_requests);
        $display("with random stalls on both sides and a %0d-cycle result hold-off; %0d failures.",
                 HOLD_CYCLES, fail_count);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #30_000_000;
        $display("Timeout with %0d results outstanding", expected_results.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/gdc_pkg.sv
rtl/core/gdc_step_unit.sv
rtl/core/gdc_seq.sv
rtl/core/gregorian_date_day_number_converter_core.sv
rtl/core/gdc_checker.sv
dv/gregorian_date_day_number_converter_core_tb.sv
